// ===== rtl/rtcm_pkg.sv =====
// Shared types, widths and helpers of the rectangle tile cover map.
// Used by every module under rtl/; depends on nothing else.

package rtcm_pkg;

    // Field widths of the stream and configuration ports.
    localparam int TILE_W = 13;     // tile size register width
    localparam int POS_W  = 15;     // rectangle edge
    localparam int LEN_W  = 16;     // rectangle extent
    localparam int END_W  = 17;     // far edge, x plus width
    localparam int EXT_W  = END_W + 1;
    localparam int OFF_W  = 12;     // offset inside a tile
    localparam int DST_W  = 16;     // destination position
    localparam int BLK_W  = 13;     // clipped block size
    localparam int CNT_W  = 6;      // tile count minus one, up to 63
    localparam int IN_W   = 64;     // 62 bits of fields padded to bytes
    localparam int OUT_W  = 88;     // 82 bits of fields padded to bytes
    localparam int CFG_IDX_W = 1;

    localparam logic [TILE_W-1:0] TILE_MAX   = 13'd4096;
    localparam logic [TILE_W-1:0] TILE_RESET = 13'd64;

    localparam int MAX_TILES_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TILE_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_H = 1'b1;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DIV_A,
        FS_DIV_B,
        FS_CHECK,
        FS_PUSH
    } t_front_state;

    // One axis of a decoded rectangle.
    typedef struct packed {
        logic [POS_W-1:0] pos;      // near edge
        logic [END_W-1:0] stop;     // far edge, exclusive
        logic [POS_W-1:0] origin;   // origin of the first tile touched
        logic [CNT_W-1:0] cnt_m1;   // tiles touched minus one
    } t_axis_job;

    typedef struct packed {
        logic      too_many;
        t_axis_job x;
        t_axis_job y;
    } t_job;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [DST_W-1:0] dst;
        logic [BLK_W-1:0] len;
    } t_clip;

    typedef struct packed {
        logic             too_many;
        logic             last;
        logic [BLK_W-1:0] block_h;
        logic [BLK_W-1:0] block_w;
        logic [DST_W-1:0] dst_y;
        logic [DST_W-1:0] dst_x;
        logic [OFF_W-1:0] src_y;
        logic [OFF_W-1:0] src_x;
    } t_result;

    // Zero means one pixel, anything above 4096 means 4096.
    function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
        logic [TILE_W-1:0] c;
        if (v == '0) begin
            c = {{(TILE_W-1){1'b0}}, 1'b1};
        end else if (v > TILE_MAX) begin
            c = TILE_MAX;
        end else begin
            c = v;
        end
        return c;
    endfunction

    // Clips one tile [t, t+ts) against the span [p, e).
    function automatic t_clip axis_clip(input logic [END_W-1:0] t,
                                        input logic [POS_W-1:0] p,
                                        input logic [END_W-1:0] e,
                                        input logic [TILE_W-1:0] ts);
        logic [END_W-1:0] d;
        logic [EXT_W-1:0] tn;
        logic [EXT_W-1:0] en;
        t_clip            c;
        d     = (t < END_W'(p)) ? END_W'(p) : t;
        tn    = EXT_W'(t) + EXT_W'(ts);
        en    = (tn < EXT_W'(e)) ? tn : EXT_W'(e);
        c.off = OFF_W'(d - t);
        c.dst = d[DST_W-1:0];
        c.len = BLK_W'(en - EXT_W'(d));
        return c;
    endfunction

endpackage

// ===== rtl/rtcm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the tile grid math.
// Depends on rtcm_pkg for the dividend and divisor widths.

module rtcm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rtcm_pkg::END_W-1:0]  i_dividend,
    input  logic [rtcm_pkg::TILE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [rtcm_pkg::END_W-1:0]  o_quot,
    output logic [rtcm_pkg::TILE_W-1:0] o_rem
);

    localparam int NW    = rtcm_pkg::END_W;
    localparam int DW    = rtcm_pkg::TILE_W;
    localparam int STEPW = $clog2(NW + 1);

    logic [NW-1:0]    r_q;
    logic [DW-1:0]    r_r;
    logic [DW-1:0]    r_d;
    logic [STEPW-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW-1:0]    n_trial;
    logic             n_fit;

    // The remainder stays below the divisor, so its top bit is always clear.
    always_comb begin
        n_trial = {r_r[DW-2:0], r_q[NW-1]};
        n_fit   = (n_trial >= r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEPW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[NW-2:0], n_fit};
            r_r <= n_fit ? (n_trial - r_d) : n_trial;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ===== rtl/rtcm_front.sv =====
// Front end: accepts rectangles, finds the tile span of each axis with two
// dividers and pushes a decoded job. Depends on rtcm_pkg and rtcm_div.

module rtcm_front #(
    parameter int MAX_TILES = rtcm_pkg::MAX_TILES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rtcm_pkg::TILE_W-1:0] i_tile_w,
    input  logic [rtcm_pkg::TILE_W-1:0] i_tile_h,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [rtcm_pkg::IN_W-1:0]   i_s_tdata,
    output logic                        o_job_valid,
    input  logic                        i_job_ready,
    output rtcm_pkg::t_job              o_job
);

    localparam int POS_W = rtcm_pkg::POS_W;
    localparam int LEN_W = rtcm_pkg::LEN_W;
    localparam int END_W = rtcm_pkg::END_W;
    localparam int CNT_W = rtcm_pkg::CNT_W;
    localparam int NUM_W = CNT_W + 1;
    localparam int PRD_W = 2 * NUM_W;

    rtcm_pkg::t_front_state r_state, n_state;

    logic [POS_W-1:0] r_rx, r_ry, r_org_x, r_org_y;
    logic [LEN_W-1:0] r_rw, r_rh;
    rtcm_pkg::t_job   r_job;

    logic [POS_W-1:0] in_rx, in_ry;
    logic [LEN_W-1:0] in_rw, in_rh;
    logic             in_live;
    logic             accept;

    logic             div_start;
    logic [END_W-1:0] div_x_num, div_y_num;
    logic             div_x_done, div_y_done;
    logic [END_W-1:0] div_x_quot, div_y_quot;
    logic [rtcm_pkg::TILE_W-1:0] div_x_rem, div_y_rem;

    logic             big;
    logic [NUM_W-1:0] num_x, num_y;
    logic [PRD_W-1:0] prod;

    assign in_rx   = i_s_tdata[POS_W-1:0];
    assign in_ry   = i_s_tdata[2*POS_W-1:POS_W];
    assign in_rw   = i_s_tdata[2*POS_W+LEN_W-1:2*POS_W];
    assign in_rh   = i_s_tdata[2*POS_W+2*LEN_W-1:2*POS_W+LEN_W];
    assign in_live = (in_rw != '0) && (in_rh != '0);
    assign accept  = i_s_tvalid && o_s_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtcm_pkg::FS_IDLE:  if (i_s_tvalid && in_live) n_state = rtcm_pkg::FS_DIV_A;
            rtcm_pkg::FS_DIV_A: if (div_x_done) n_state = rtcm_pkg::FS_DIV_B;
            rtcm_pkg::FS_DIV_B: if (div_x_done) n_state = rtcm_pkg::FS_CHECK;
            rtcm_pkg::FS_CHECK: n_state = rtcm_pkg::FS_PUSH;
            rtcm_pkg::FS_PUSH:  if (i_job_ready) n_state = rtcm_pkg::FS_IDLE;
            default:            n_state = rtcm_pkg::FS_IDLE;
        endcase
    end

    // Outputs of the sequencer. An empty rectangle is taken and dropped.
    always_comb begin
        o_s_tready  = 1'b0;
        o_job_valid = 1'b0;
        div_start   = 1'b0;
        div_x_num   = END_W'(in_rx);
        div_y_num   = END_W'(in_ry);
        unique case (r_state)
            rtcm_pkg::FS_IDLE: begin
                o_s_tready = 1'b1;
                div_start  = i_s_tvalid && in_live;
            end
            rtcm_pkg::FS_DIV_A: begin
                // Second pass: tiles beyond the first one, (rem + len - 1) / size.
                div_start = div_x_done;
                div_x_num = END_W'(div_x_rem) + END_W'(r_rw) - END_W'(1);
                div_y_num = END_W'(div_y_rem) + END_W'(r_rh) - END_W'(1);
            end
            rtcm_pkg::FS_DIV_B: begin
            end
            rtcm_pkg::FS_CHECK: begin
            end
            rtcm_pkg::FS_PUSH: begin
                o_job_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    rtcm_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_x_num),
        .i_divisor  (i_tile_w),
        .o_done     (div_x_done),
        .o_quot     (div_x_quot),
        .o_rem      (div_x_rem)
    );

    rtcm_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_y_num),
        .i_divisor  (i_tile_h),
        .o_done     (div_y_done),
        .o_quot     (div_y_quot),
        .o_rem      (div_y_rem)
    );

    // Tile count check; the counts are small once both axes are known to fit.
    always_comb begin
        big   = (div_x_quot >= END_W'(MAX_TILES)) || (div_y_quot >= END_W'(MAX_TILES));
        num_x = NUM_W'(div_x_quot[CNT_W-1:0]) + NUM_W'(1);
        num_y = NUM_W'(div_y_quot[CNT_W-1:0]) + NUM_W'(1);
        prod  = PRD_W'(num_x) * PRD_W'(num_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtcm_pkg::FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rx <= in_rx;
            r_ry <= in_ry;
            r_rw <= in_rw;
            r_rh <= in_rh;
        end
        if (r_state == rtcm_pkg::FS_DIV_A && div_x_done) begin
            r_org_x <= r_rx - POS_W'(div_x_rem);
            r_org_y <= r_ry - POS_W'(div_y_rem);
        end
        if (r_state == rtcm_pkg::FS_CHECK) begin
            r_job.too_many <= big || (prod > PRD_W'(MAX_TILES));
            r_job.x.pos    <= r_rx;
            r_job.x.stop   <= END_W'(r_rx) + END_W'(r_rw);
            r_job.x.origin <= r_org_x;
            r_job.x.cnt_m1 <= div_x_quot[CNT_W-1:0];
            r_job.y.pos    <= r_ry;
            r_job.y.stop   <= END_W'(r_ry) + END_W'(r_rh);
            r_job.y.origin <= r_org_y;
            r_job.y.cnt_m1 <= div_y_quot[CNT_W-1:0];
        end
    end

    assign o_job = r_job;

    // Both dividers run the same number of steps and must finish together.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_x_done == div_y_done)
        else $error("x and y dividers finished in different cycles");

    // A job is offered only after both division passes have completed.
    a_push_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_job_valid) |-> $past(r_state) == rtcm_pkg::FS_CHECK)
        else $error("job offered without a completed tile count check");

endmodule

// ===== rtl/rtcm_queue.sv =====
// Short job queue between the front end and the tile walker.
// Depends on rtcm_pkg for the job type.

module rtcm_queue #(
    parameter int DEPTH = rtcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  rtcm_pkg::t_job i_job,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output rtcm_pkg::t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtcm_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("job queue fill count ran past its depth");

endmodule

// ===== rtl/rtcm_back.sv =====
// Back end: walks the tiles of one job, x outer and y inner, and holds each
// result in an output register. Depends on rtcm_pkg.

module rtcm_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rtcm_pkg::TILE_W-1:0] i_tile_w,
    input  logic [rtcm_pkg::TILE_W-1:0] i_tile_h,
    input  logic                        i_job_valid,
    output logic                        o_job_ready,
    input  rtcm_pkg::t_job              i_job,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output rtcm_pkg::t_result           o_result
);

    localparam int END_W = rtcm_pkg::END_W;
    localparam int CNT_W = rtcm_pkg::CNT_W;

    logic              r_busy;
    rtcm_pkg::t_job    r_job;
    logic [END_W-1:0]  r_tx, r_ty;
    logic [CNT_W-1:0]  r_ci, r_ri;
    logic              r_out_valid;
    rtcm_pkg::t_result r_out;

    rtcm_pkg::t_clip   clip_x, clip_y;
    rtcm_pkg::t_result n_out;
    logic              col_end, tile_last, step;

    assign o_job_ready = !r_busy;
    assign step        = r_busy && (!r_out_valid || i_m_tready);
    assign col_end     = (r_ri == r_job.y.cnt_m1);
    assign tile_last   = r_job.too_many || (col_end && (r_ci == r_job.x.cnt_m1));

    always_comb begin
        clip_x = rtcm_pkg::axis_clip(r_tx, r_job.x.pos, r_job.x.stop, i_tile_w);
        clip_y = rtcm_pkg::axis_clip(r_ty, r_job.y.pos, r_job.y.stop, i_tile_h);
        n_out  = '0;
        n_out.too_many = r_job.too_many;
        n_out.last     = tile_last;
        if (!r_job.too_many) begin
            n_out.src_x   = clip_x.off;
            n_out.src_y   = clip_y.off;
            n_out.dst_x   = clip_x.dst;
            n_out.dst_y   = clip_y.dst;
            n_out.block_w = clip_x.len;
            n_out.block_h = clip_y.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (!r_busy && i_job_valid) begin
                r_busy <= 1'b1;
            end
            if (step) begin
                r_out_valid <= 1'b1;
                if (tile_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_job_valid) begin
            r_job <= i_job;
            r_tx  <= END_W'(i_job.x.origin);
            r_ty  <= END_W'(i_job.y.origin);
            r_ci  <= '0;
            r_ri  <= '0;
        end else if (step) begin
            if (col_end) begin
                r_ri <= '0;
                r_ty <= END_W'(r_job.y.origin);
                r_ci <= r_ci + 1'b1;
                r_tx <= r_tx + END_W'(i_tile_w);
            end else begin
                r_ri <= r_ri + 1'b1;
                r_ty <= r_ty + END_W'(i_tile_h);
            end
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;

    // An overflow beat ends its rectangle and carries no block.
    a_overflow_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.too_many |-> r_out.last && r_out.block_w == '0
            && r_out.block_h == '0)
        else $error("overflow beat with a block or without last");

    // Every regular tile touched covers at least one pixel on each axis.
    a_tile_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.too_many |-> r_out.block_w != '0 && r_out.block_h != '0)
        else $error("tile beat with an empty block");

    // The column index never walks past the job's column count.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_job.too_many |-> r_ci <= r_job.x.cnt_m1)
        else $error("tile walker ran past the last column");

endmodule

// ===== rtl/rect_tile_cover_map_top.sv =====
// Top level of the rectangle tile cover map: configuration registers, front
// end, job queue and tile walker. Depends on rtcm_pkg, rtcm_front,
// rtcm_queue and rtcm_back.
//
//  Channel   Direction  Handshake                       Beat carries
//  --------  ---------  ------------------------------  -------------------------------
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready one rectangle x, y, w, h
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready one tile block, tlast, tuser
//  cfg       in         i_cfg_valid/o_cfg_ready         tile width or tile height
//
// The front end takes a rectangle, then runs two passes in a pair of bit-serial
// dividers (one per axis), a check and a hand-off before it takes the next one.
// The tile walker loads each job and then gives one beat per tile, one per cycle
// while m_axis is not stalled; the queue lets the front end work on the next
// rectangle while the walker is still busy with earlier ones.
// A rectangle with a zero width or height is taken and gives no beat.
// Reset is synchronous and active low; it returns both tile sizes to 64 and
// empties the queue. A stall on m_axis holds the current tile and backs up
// into the queue, then the front end, then s_axis.

module rect_tile_cover_map_top #(
    parameter int MAX_TILES   = rtcm_pkg::MAX_TILES_DEF,
    parameter int QUEUE_DEPTH = rtcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Rectangle input.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // rect_x[14:0], rect_y[29:15], rect_w[45:30], rect_h[61:46], zero[63:62]
    input  logic [rtcm_pkg::IN_W-1:0]      i_s_axis_tdata,
    // Tile output.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // src_x[11:0], src_y[23:12], dst_x[39:24], dst_y[55:40],
    // block_w[68:56], block_h[81:69], zero[87:82]
    output logic [rtcm_pkg::OUT_W-1:0]     o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    // too_many[0]
    output logic [0:0]                     o_m_axis_tuser,
    // Configuration writes.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rtcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rtcm_pkg::TILE_W-1:0]    i_cfg_data
);

    logic [rtcm_pkg::TILE_W-1:0] r_tile_w, r_tile_h;
    logic [rtcm_pkg::TILE_W-1:0] tile_w, tile_h;

    logic              fe_valid, fe_ready;
    rtcm_pkg::t_job    fe_job;
    logic              q_valid, q_pop;
    rtcm_pkg::t_job    q_job;
    rtcm_pkg::t_result result;

    // The registers hold what was written; the clamp to 1..4096 is applied
    // on the way into the datapath.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w <= rtcm_pkg::TILE_RESET;
            r_tile_h <= rtcm_pkg::TILE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rtcm_pkg::REG_TILE_W: r_tile_w <= i_cfg_data;
                rtcm_pkg::REG_TILE_H: r_tile_h <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign tile_w = rtcm_pkg::clamp_tile(r_tile_w);
    assign tile_h = rtcm_pkg::clamp_tile(r_tile_h);

    rtcm_front #(
        .MAX_TILES (MAX_TILES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tile_w    (tile_w),
        .i_tile_h    (tile_h),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .o_job_valid (fe_valid),
        .i_job_ready (fe_ready),
        .o_job       (fe_job)
    );

    rtcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (fe_valid),
        .o_push_ready (fe_ready),
        .i_job        (fe_job),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_job        (q_job)
    );

    rtcm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tile_w    (tile_w),
        .i_tile_h    (tile_h),
        .i_job_valid (q_valid),
        .o_job_ready (q_pop),
        .i_job       (q_job),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_result    (result)
    );

    assign o_m_axis_tdata = {6'd0, result.block_h, result.block_w, result.dst_y,
                             result.dst_x, result.src_y, result.src_x};
    assign o_m_axis_tlast = result.last;
    assign o_m_axis_tuser = result.too_many;

endmodule
